@@ rtl/irh_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the interleaved rtp h.264 depacketizer
// no dependencies
package irh_pkg;

    localparam logic [7:0] INTERLEAVE_MAGIC = 8'h24;
    localparam logic [3:0] RTP_HDR_LEN      = 4'd12;
    localparam logic [3:0] FU_HDR_POS       = 4'd13;
    localparam logic [4:0] NAL_SINGLE_LIMIT = 5'd24;
    localparam logic [4:0] NAL_FU_A         = 5'd28;

    // start code bytes, then the nal header as the last step
    localparam int unsigned START_LEN = 4;
    localparam logic [2:0] NAL_LAST_STEP = 3'(START_LEN);
    localparam logic [7:0] START_CODE [START_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

    // command from the parser to the output sequencer
    typedef struct packed {
        logic       is_nal;   // start code followed by data as nal header
        logic [7:0] data;
    } irh_cmd_t;

endpackage

@@ rtl/irh_front.sv @@
`timescale 1ns / 1ps
// parser: walks interleave frames, rtp header and nal/fu headers
// depends on irh_pkg
module irh_front import irh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       q_full,
    output logic       cmd_push,
    output irh_cmd_t   cmd
);

    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_CHANNEL = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;
    localparam logic [2:0] PH_RTP     = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] left_reg, left_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic        rtp_reg, rtp_next;
    logic        copy_reg, copy_next;
    logic [2:0]  nri_reg, nri_next;

    logic        accept;
    logic [15:0] len_full;
    logic [15:0] left_dec;
    logic [4:0]  nal_type;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign len_full = {left_reg[15:8], s_in_byte};
    assign left_dec = left_reg - 16'd1;
    assign nal_type = s_in_byte[4:0];

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        hidx_next  = hidx_reg;
        rtp_next   = rtp_reg;
        copy_next  = copy_reg;
        nri_next   = nri_reg;
        cmd_push   = 1'b0;
        cmd.is_nal = 1'b0;
        cmd.data   = s_in_byte;
        if (accept) begin
            unique case (phase_reg)
                PH_CHANNEL: begin
                    if (s_in_byte[0]) begin
                        rtp_next = 1'b0;
                    end
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    left_next  = {s_in_byte, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    left_next = len_full;
                    hidx_next = '0;
                    copy_next = 1'b0;
                    if (len_full == 16'd0) begin
                        phase_next = PH_MAGIC;
                    end else begin
                        phase_next = rtp_reg ? PH_RTP : PH_SKIP;
                    end
                end
                PH_SKIP, PH_RTP, PH_PAYLOAD: begin
                    if (phase_reg == PH_RTP) begin
                        if (hidx_reg == RTP_HDR_LEN) begin
                            if (nal_type >= 5'd1 && nal_type < NAL_SINGLE_LIMIT) begin
                                cmd_push   = 1'b1;
                                cmd.is_nal = 1'b1;
                                copy_next  = 1'b1;
                                phase_next = PH_PAYLOAD;
                            end else if (nal_type == NAL_FU_A) begin
                                nri_next  = s_in_byte[7:5];
                                hidx_next = FU_HDR_POS;
                            end else begin
                                copy_next  = 1'b0;
                                phase_next = PH_PAYLOAD;
                            end
                        end else if (hidx_reg == FU_HDR_POS) begin
                            // rebuilt header: indicator f/nri with fu type
                            if (s_in_byte[7]) begin
                                cmd_push   = 1'b1;
                                cmd.is_nal = 1'b1;
                                cmd.data   = {nri_reg, s_in_byte[4:0]};
                            end
                            copy_next  = 1'b1;
                            phase_next = PH_PAYLOAD;
                        end else begin
                            hidx_next = hidx_reg + 4'd1;
                        end
                    end else if (phase_reg == PH_PAYLOAD) begin
                        cmd_push = copy_reg;
                    end
                    left_next = left_dec;
                    if (left_dec == 16'd0) begin
                        phase_next = PH_MAGIC;
                        copy_next  = 1'b0;
                        hidx_next  = '0;
                    end
                end
                default: begin
                    rtp_next   = (s_in_byte == INTERLEAVE_MAGIC);
                    phase_next = PH_CHANNEL;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            left_reg  <= '0;
            hidx_reg  <= '0;
            rtp_reg   <= 1'b0;
            copy_reg  <= 1'b0;
            nri_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            hidx_reg  <= hidx_next;
            rtp_reg   <= rtp_next;
            copy_reg  <= copy_next;
            nri_reg   <= nri_next;
        end
    end

endmodule

@@ rtl/irh_queue.sv @@
`timescale 1ns / 1ps
// short command queue between parser and output sequencer
// depends on irh_pkg
module irh_queue import irh_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  irh_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output irh_cmd_t head_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    irh_cmd_t      slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_reg];

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + PW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/irh_back.sv @@
`timescale 1ns / 1ps
// output sequencer: expands commands into result transfers
// depends on irh_pkg
module irh_back import irh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  irh_cmd_t   head_cmd,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_nal_start,
    output logic       m_out_last
);

    logic [2:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       start_reg, start_next;
    logic       last_reg, last_next;
    logic       out_free;
    logic       is_last;

    assign out_free = !valid_reg || m_ready;
    assign is_last  = !head_cmd.is_nal || (step_reg == NAL_LAST_STEP);
    assign pop      = out_free && head_valid && is_last;

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        start_next = start_reg;
        last_next  = last_reg;
        if (out_free) begin
            valid_next = head_valid;
            if (head_valid) begin
                if (head_cmd.is_nal && step_reg != NAL_LAST_STEP) begin
                    byte_next = START_CODE[step_reg[1:0]];
                end else begin
                    byte_next = head_cmd.data;
                end
                start_next = head_cmd.is_nal && (step_reg == 3'd0);
                last_next  = is_last;
                step_next  = is_last ? 3'd0 : step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        start_reg <= start_next;
        last_reg  <= last_next;
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_nal_start = start_reg;
    assign m_out_last  = last_reg;

endmodule

@@ rtl/interleaved_rtp_h264_depacketizer_top.sv @@
`timescale 1ns / 1ps
// top level of the interleaved rtp h.264 depacketizer
// depends on irh_pkg, irh_front, irh_queue, irh_back
//
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_in_byte[7:0]
// m_       out  m_valid/m_ready    m_out_byte[7:0], m_nal_start, m_out_last
//
// the parser takes one stream byte per cycle while the command queue has room
// a copied byte gives one result, a nal start five (start code + header);
// the output sequencer steps out one result per cycle unless the result side stalls
// an input byte passes the combinational parser, then the queue and the output register
// synchronous active-low reset clears parser state, queue and output valid
// either side may stall; the queue decouples parser and sequencer
module interleaved_rtp_h264_depacketizer_top import irh_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_nal_start,
    output logic       m_out_last
);

    // parser to queue
    logic     cmd_push;
    irh_cmd_t cmd;
    logic     q_full;

    // queue to sequencer
    logic     q_pop;
    logic     q_valid;
    irh_cmd_t q_cmd;

    irh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    irh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    irh_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_valid),
        .head_cmd    (q_cmd),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_nal_start (m_nal_start),
        .m_out_last  (m_out_last)
    );

endmodule

@@ rtl/irh_checker.sv @@
`timescale 1ns / 1ps
// port-level checks on the depacketizer result channel, bound to the top level
// depends on interleaved_rtp_h264_depacketizer_top
module irh_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_nal_start,
    input logic       m_out_last
);

    // stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_nal_start) && $stable(m_out_last))
        else $error("stalled result changed");

    // start code opens with a zero byte
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nal_start |-> m_out_byte == 8'h00)
        else $error("start code byte not zero");

    // start code never ends an input byte's results
    a_start_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nal_start |-> !m_out_last)
        else $error("start code marked last");

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind interleaved_rtp_h264_depacketizer_top irh_checker u_irh_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_nal_start (m_nal_start),
    .m_out_last  (m_out_last)
);

@@ bench/interleaved_rtp_h264_depacketizer_top_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for the interleaved rtp h.264 depacketizer top level
// depends on irh_pkg and interleaved_rtp_h264_depacketizer_top
module interleaved_rtp_h264_depacketizer_top_test;
    import irh_pkg::*;

    // parser phases of the bench's own copy of the depacketizer
    typedef enum logic [3:0] {
        ST_SYNC    = 4'd0,
        ST_CHANNEL = 4'd1,
        ST_LEN_HI  = 4'd2,
        ST_LEN_LO  = 4'd3,
        ST_SKIP    = 4'd4,
        ST_RTP     = 4'd5,
        ST_PAYLOAD = 4'd6
    } parse_phase_t;

    typedef enum logic [1:0] {
        MODE_DISCARD = 2'd0,
        MODE_COPY    = 2'd1
    } payload_mode_t;

    // one byte of the annex b output stream
    typedef struct packed {
        logic [7:0] out_byte;
        logic       nal_start;
        logic       out_last;
    } es_beat_t;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_BYTES  = 1;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_nal_start;
    logic       m_out_last;

    interleaved_rtp_h264_depacketizer_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_nal_start(m_nal_start),
        .m_out_last (m_out_last)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predicted annex b stream, oldest first
    es_beat_t expected_es_q[$];
    // beats caused by the byte now being predicted
    es_beat_t step_beats[$];
    // body of the frame being built by a test
    logic [7:0] frame_body[$];

    int fail_count = 0;
    int cycle_count = 0;
    int sink_stall = 0;
    int random_sent = 0;
    // when set neither side idles
    bit steady_flow = 1'b0;

    // bench copy of the parser state
    parse_phase_t  pred_phase = ST_SYNC;
    logic [15:0]   pred_left = 16'h0000;
    logic [3:0]    pred_hidx = 4'h0;
    logic          pred_is_rtp = 1'b0;
    payload_mode_t pred_mode = MODE_DISCARD;
    logic [7:0]    pred_indicator = 8'h00;

    // start code then the nal header byte
    task automatic append_nal_start(input logic [7:0] hdr);
        es_beat_t beat;
        for (int k = 0; k < START_LEN; k++) begin
            beat.out_byte  = START_CODE[k];
            beat.nal_start = (k == 0);
            beat.out_last  = 1'b0;
            step_beats.push_back(beat);
        end
        beat.out_byte  = hdr;
        beat.nal_start = 1'b0;
        beat.out_last  = 1'b0;
        step_beats.push_back(beat);
    endtask

    // advance the bench parser by one stream byte and queue what it emits
    task automatic predict_stream_byte(input logic [7:0] b);
        logic [4:0] nal_type;
        bit         in_body;
        es_beat_t   beat;
        nal_type = b[4:0];
        in_body  = 1'b0;
        step_beats.delete();
        case (pred_phase)
            ST_CHANNEL: begin
                // odd channel is rtcp or other traffic
                if (b[0]) pred_is_rtp = 1'b0;
                pred_phase = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                pred_left  = {b, 8'h00};
                pred_phase = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                pred_left  = pred_left | {8'h00, b};
                pred_hidx  = 4'h0;
                pred_mode  = MODE_DISCARD;
                if (pred_left == 16'h0000) pred_phase = ST_SYNC;
                else pred_phase = pred_is_rtp ? ST_RTP : ST_SKIP;
            end
            ST_SKIP: in_body = 1'b1;
            ST_RTP: begin
                in_body = 1'b1;
                if (pred_hidx == RTP_HDR_LEN) begin
                    if (nal_type >= 5'd1 && nal_type < NAL_SINGLE_LIMIT) begin
                        append_nal_start(b);
                        pred_mode  = MODE_COPY;
                        pred_phase = ST_PAYLOAD;
                    end else if (nal_type == NAL_FU_A) begin
                        pred_indicator = b;
                        pred_hidx      = FU_HDR_POS;
                    end else begin
                        pred_mode  = MODE_DISCARD;
                        pred_phase = ST_PAYLOAD;
                    end
                end else if (pred_hidx == FU_HDR_POS) begin
                    // fu start bit rebuilds the nal header
                    if (b[7]) append_nal_start({pred_indicator[7:5], b[4:0]});
                    pred_mode  = MODE_COPY;
                    pred_phase = ST_PAYLOAD;
                end else begin
                    pred_hidx = pred_hidx + 4'd1;
                end
            end
            ST_PAYLOAD: begin
                in_body = 1'b1;
                if (pred_mode == MODE_COPY) begin
                    beat.out_byte  = b;
                    beat.nal_start = 1'b0;
                    beat.out_last  = 1'b0;
                    step_beats.push_back(beat);
                end
            end
            default: begin
                pred_is_rtp = (b == INTERLEAVE_MAGIC);
                pred_phase  = ST_CHANNEL;
            end
        endcase
        if (in_body) begin
            pred_left = pred_left - 16'd1;
            if (pred_left == 16'h0000) begin
                pred_phase = ST_SYNC;
                pred_mode  = MODE_DISCARD;
                pred_hidx  = 4'h0;
            end
        end
        if (step_beats.size() > 0) begin
            step_beats[step_beats.size() - 1].out_last = 1'b1;
            foreach (step_beats[i]) expected_es_q.push_back(step_beats[i]);
        end
    endtask

    // one stream byte transfer; called and returning at a rising edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        // predicted ahead of the transfer, bytes are taken in order
        predict_stream_byte(b);
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // prefix then len body bytes, taken from frame_body and padded at random
    task automatic send_frame(input logic [7:0] magic, input logic [7:0] chan,
                              input logic [15:0] len);
        send_byte(magic);
        send_byte(chan);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int i = 0; i < int'(len); i++)
            send_byte(i < frame_body.size() ? frame_body[i] : 8'($urandom));
    endtask

    task automatic start_rtp_body();
        frame_body.delete();
        repeat (RTP_HDR_LEN) frame_body.push_back(8'($urandom));
    endtask

    task automatic send_rtp_frame();
        send_frame(INTERLEAVE_MAGIC, 8'h00, 16'(frame_body.size()));
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_es_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // zero length, foreign magic and odd channel frames
    task automatic test_frame_prefix();
        frame_body.delete();
        send_frame(INTERLEAVE_MAGIC, 8'h00, 16'h0000);
        frame_body = '{8'h00, 8'hff, 8'h24};
        send_frame(8'h00, 8'h00, 16'd3);
        start_rtp_body();
        frame_body.push_back(8'h41);
        frame_body.push_back(8'h5a);
        send_frame(INTERLEAVE_MAGIC, 8'h01, 16'(frame_body.size()));
        frame_body = '{8'h7f, 8'h80};
        send_frame(8'hff, 8'hfe, 16'd2);
    endtask

    // frames that end inside the headers
    task automatic test_short_packets();
        start_rtp_body();
        send_frame(INTERLEAVE_MAGIC, 8'h02, 16'd5);
        // ends right after a single nal header
        start_rtp_body();
        frame_body.push_back(8'h61);
        send_rtp_frame();
        // ends right after an fu indicator
        start_rtp_body();
        frame_body.push_back(8'h7c);
        send_rtp_frame();
    endtask

    // lowest and highest single nal types with payload extremes, sent without idling
    task automatic test_single_nal();
        steady_flow = 1'b1;
        start_rtp_body();
        frame_body.push_back(8'h01);
        frame_body.push_back(8'h00);
        frame_body.push_back(8'hff);
        send_rtp_frame();
        start_rtp_body();
        frame_body.push_back(8'hf7);
        frame_body.push_back(8'h55);
        frame_body.push_back(8'haa);
        send_frame(INTERLEAVE_MAGIC, 8'hfe, 16'(frame_body.size()));
        steady_flow = 1'b0;
    endtask

    // fu-a start with forbidden bit set, then a continuation fragment
    task automatic test_fu_a();
        start_rtp_body();
        frame_body.push_back(8'hfc);
        frame_body.push_back(8'h85);
        frame_body.push_back(8'h11);
        frame_body.push_back(8'h22);
        send_rtp_frame();
        start_rtp_body();
        frame_body.push_back(8'h5c);
        frame_body.push_back(8'h05);
        frame_body.push_back(8'h33);
        send_rtp_frame();
    endtask

    // stap-a, type zero and type 31 are dropped whole
    task automatic test_discarded_types();
        logic [7:0] hdrs[3];
        hdrs = '{8'h78, 8'h00, 8'hff};
        foreach (hdrs[i]) begin
            start_rtp_body();
            frame_body.push_back(hdrs[i]);
            frame_body.push_back(8'h12);
            send_rtp_frame();
        end
    endtask

    // sender holds off until the output stream has fully drained
    task automatic test_drain_pause();
        start_rtp_body();
        frame_body.push_back(8'h7c);
        frame_body.push_back(8'h81);
        frame_body.push_back(8'h99);
        send_rtp_frame();
        wait_for_drain();
        start_rtp_body();
        frame_body.push_back(8'h68);
        frame_body.push_back(8'h01);
        send_rtp_frame();
    endtask

    // mostly well formed rtp frames, some truncated, some noise frames
    task automatic test_random_frames();
        int         pick;
        int         plen;
        int         full;
        logic [7:0] nal;
        logic [7:0] chan;
        while (random_sent < RANDOM_BYTES) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                start_rtp_body();
                case ($urandom_range(0, 3))
                    0, 1: nal = {3'($urandom), 5'(NAL_FU_A)};
                    2:    nal = {3'($urandom), 5'($urandom_range(1, 23))};
                    default: nal = 8'($urandom);
                endcase
                frame_body.push_back(nal);
                if (nal[4:0] == NAL_FU_A) frame_body.push_back(8'($urandom));
                plen = $urandom_range(0, 8);
                repeat (plen) frame_body.push_back(8'($urandom));
                full = frame_body.size();
                // occasionally cut the packet short
                if (pick == 7) full = $urandom_range(0, full);
                chan = {7'($urandom), 1'b0};
                send_frame(INTERLEAVE_MAGIC, chan, 16'(full));
                random_sent += 4 + full;
            end else begin
                frame_body.delete();
                full = $urandom_range(0, 8);
                if (pick == 8) send_frame(8'($urandom), 8'($urandom), 16'(full));
                else send_frame(INTERLEAVE_MAGIC, {7'($urandom), 1'b1}, 16'(full));
                random_sent += 4 + full;
            end
        end
        steady_flow = 1'b0;
    endtask

    // result side: ready stalls drawn per transfer, every result checked in order
    always @(posedge aclk) begin : result_check
        es_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_es_q.size() == 0) begin
                $error("result with none expected: out_byte %02h", m_out_byte);
                fail_count++;
            end else begin
                want = expected_es_q.pop_front();
                if (m_out_byte !== want.out_byte) begin
                    $error("out_byte expected %02h actual %02h", want.out_byte, m_out_byte);
                    fail_count++;
                end
                if (m_nal_start !== want.nal_start) begin
                    $error("nal_start expected %0b actual %0b", want.nal_start, m_nal_start);
                    fail_count++;
                end
                if (m_out_last !== want.out_last) begin
                    $error("out_last expected %0b actual %0b", want.out_last, m_out_last);
                    fail_count++;
                end
            end
            sink_stall = steady_flow ? 0 : $urandom_range(0, 10);
        end else if (sink_stall > 0) begin
            sink_stall--;
        end
        m_ready <= aresetn && (sink_stall == 0);
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("interleaved_rtp_h264_depacketizer_top verification failed");
            $finish;
        end
    end

    initial begin
        // reset held low from the start, released once
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_frame_prefix();
        test_short_packets();
        test_single_nal();
        test_fu_a();
        test_discarded_types();
        test_drain_pause();
        test_random_frames();

        wait_for_drain();
        if (fail_count == 0) begin
            $display("interleaved_rtp_h264_depacketizer_top verification clean");
        end else begin
            $display("interleaved_rtp_h264_depacketizer_top verification failed");
        end
        $finish;
    end

endmodule
